[rtl/tcma_pkg.sv]
// ============================================================================
// tcma_pkg: shared types and constants for the two-channel moving average
// Holds the channel tag encoding and the sizing constant for the fixed-point
// reciprocal that turns a running sum into a truncated mean.
// ============================================================================
package tcma_pkg;

    typedef enum logic
    {
        CH_SHORT = 1'b0,
        CH_LONG  = 1'b1
    } channel_t;

    // Number of bits that covers the largest supported window (256).
    localparam int WINDOW_LOG2_MAX = 8;

endpackage

[rtl/tcma_if.sv]
// ============================================================================
// tcma_if: stream interfaces of the two-channel moving average
// One interface carries tagged input samples, the other carries the channel
// and mean of each result. Both use a valid/ready handshake.
// ============================================================================
interface tcma_sample_if #(
    parameter int SAMPLE_BITS = 12
);
    import tcma_pkg::*;

    logic                   valid;
    logic                   ready;
    channel_t               channel;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);

endinterface

interface tcma_mean_if #(
    parameter int SAMPLE_BITS = 12
);
    import tcma_pkg::*;

    logic                   valid;
    logic                   ready;
    channel_t               channel_out;
    logic [SAMPLE_BITS-1:0] mean;

    modport source (output valid, output channel_out, output mean, input ready);
    modport sink   (input valid, input channel_out, input mean, output ready);

endinterface

[rtl/tcma_ring.sv]
// ============================================================================
// tcma_ring: sample ring and running sum of one channel
// Writes each pushed sample over the oldest entry and returns the updated
// sum. The entry that will be overwritten next is read one push ahead.
// ============================================================================
module tcma_ring #(
    parameter int WINDOW      = 16,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic [SAMPLE_BITS-1:0]                 sample,
    output logic [SAMPLE_BITS+$clog2(WINDOW)-1:0]  new_sum
);

    localparam int PTR_BITS = $clog2(WINDOW);
    localparam int SUM_BITS = SAMPLE_BITS + PTR_BITS;

    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];

    logic [PTR_BITS-1:0]    ptr_reg;
    logic [PTR_BITS-1:0]    ptr_next;
    logic                   wrapped_reg;
    logic                   wrapped_next;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SAMPLE_BITS-1:0] oldest_reg;
    logic [SAMPLE_BITS-1:0] oldest;
    logic                   at_last;

    assign at_last = (ptr_reg == PTR_BITS'(WINDOW - 1));

    // Until the ring has gone round once, the entry being replaced has never
    // been written and counts as zero.
    assign oldest = wrapped_reg ? oldest_reg : '0;

    always_comb
    begin
        ptr_next     = ptr_reg;
        wrapped_next = wrapped_reg;
        sum_next     = sum_reg;
        if (push)
        begin
            ptr_next     = at_last ? '0 : ptr_reg + 1'b1;
            wrapped_next = wrapped_reg | at_last;
            sum_next     = sum_reg - SUM_BITS'(oldest) + SUM_BITS'(sample);
        end
    end

    assign new_sum = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            wrapped_reg <= wrapped_next;
            sum_reg     <= sum_next;
        end
    end

    // The read address is the next write slot, which differs from the slot
    // written in the same cycle, so the read returns the oldest sample.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[ptr_reg] <= sample;
            oldest_reg        <= ring_mem[ptr_next];
        end
    end

endmodule

[rtl/two_channel_moving_average.sv]
// ============================================================================
// two_channel_moving_average: boxcar average over two tagged channels
// Keeps a ring and running sum per channel and returns the truncated mean of
// the tagged channel's last window of samples for every input beat.
// ============================================================================
// One input beat is taken every clock cycle unless stalled and yields exactly
// one result beat, in input order, via the s1, s2 and output registers. The
// rate is set by the ring update: each channel's ring memory is written once
// per beat while the entry to be replaced next is read ahead, so the running
// sum updates in the accept cycle. The mean is then formed by a multiply with
// a fixed-point reciprocal of the window (exact truncation for any window
// from 2 to 256) and a shift. The rings count as all zeros after reset, so
// early means include zeros; no clearing pass is needed. Backpressure on the
// result side stalls the pipeline stage by stage, and the input stays ready
// while a finished result waits as long as a stage ahead of it is free.
module two_channel_moving_average #(
    parameter int SHORT_WINDOW = 16,
    parameter int LONG_WINDOW  = 32,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    tcma_sample_if.sink   samples,
    tcma_mean_if.source   means
);
    import tcma_pkg::*;

    localparam int SHORT_SUM_BITS = SAMPLE_BITS + $clog2(SHORT_WINDOW);
    localparam int LONG_SUM_BITS  = SAMPLE_BITS + $clog2(LONG_WINDOW);
    localparam int SUM_BITS       = (SHORT_SUM_BITS > LONG_SUM_BITS) ?
                                    SHORT_SUM_BITS : LONG_SUM_BITS;
    localparam int RECIP_SHIFT    = SUM_BITS + WINDOW_LOG2_MAX;
    localparam int RECIP_BITS     = SUM_BITS + WINDOW_LOG2_MAX;
    localparam int PROD_BITS      = SUM_BITS + RECIP_BITS;

    // Rounded-up reciprocals: floor(sum * recip / 2^shift) equals the exact
    // floor(sum / window) for every sum below 2^SUM_BITS.
    localparam logic [63:0] SHORT_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(SHORT_WINDOW) - 64'd1) / 64'(SHORT_WINDOW);
    localparam logic [63:0] LONG_RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(LONG_WINDOW) - 64'd1) / 64'(LONG_WINDOW);

    logic                      accept;
    logic                      short_push;
    logic                      long_push;
    logic [SHORT_SUM_BITS-1:0] short_sum;
    logic [LONG_SUM_BITS-1:0]  long_sum;

    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    channel_t                  s1_channel_reg;
    logic [SUM_BITS-1:0]       s1_sum_reg;
    logic [SUM_BITS-1:0]       s1_sum_next;

    logic                      s2_valid_reg;
    logic                      s2_valid_next;
    channel_t                  s2_channel_reg;
    logic [PROD_BITS-1:0]      s2_product_reg;
    logic [PROD_BITS-1:0]      s2_product_next;
    logic [RECIP_BITS-1:0]     recip_sel;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    channel_t                  out_channel_reg;
    logic [SAMPLE_BITS-1:0]    out_mean_reg;

    logic                      out_load;
    logic                      s2_load;
    logic                      s2_free;
    logic                      s1_free;

    // Stage handshake, from the result side back to the input.
    assign out_load = s2_valid_reg && (!out_valid_reg || means.ready);
    assign s2_free  = !s2_valid_reg || out_load;
    assign s2_load  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_load;

    assign samples.ready = s1_free;
    assign accept        = samples.valid && s1_free;
    assign short_push    = accept && (samples.channel == CH_SHORT);
    assign long_push     = accept && (samples.channel == CH_LONG);

    tcma_ring #(
        .WINDOW      (SHORT_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_short_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (short_push),
        .sample  (samples.sample),
        .new_sum (short_sum)
    );

    tcma_ring #(
        .WINDOW      (LONG_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_long_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (long_push),
        .sample  (samples.sample),
        .new_sum (long_sum)
    );

    assign s1_sum_next = (samples.channel == CH_SHORT) ? SUM_BITS'(short_sum)
                                                       : SUM_BITS'(long_sum);

    assign recip_sel = (s1_channel_reg == CH_SHORT) ? SHORT_RECIP[RECIP_BITS-1:0]
                                                    : LONG_RECIP[RECIP_BITS-1:0];

    assign s2_product_next = PROD_BITS'(s1_sum_reg) * PROD_BITS'(recip_sel);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (means.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_channel_reg <= samples.channel;
            s1_sum_reg     <= s1_sum_next;
        end
        if (s2_load)
        begin
            s2_channel_reg <= s1_channel_reg;
            s2_product_reg <= s2_product_next;
        end
        if (out_load)
        begin
            out_channel_reg <= s2_channel_reg;
            out_mean_reg    <= s2_product_reg[RECIP_SHIFT +: SAMPLE_BITS];
        end
    end

    assign means.valid       = out_valid_reg;
    assign means.channel_out = out_channel_reg;
    assign means.mean        = out_mean_reg;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the two-channel moving average
// Drives tagged samples through a directed table and then through random
// blocks of items. A local ring-and-sum model predicts each mean, and every
// result beat is compared with the oldest expected mean. Both handshake sides
// idle at random.
// ============================================================================
module testbench;
    import tcma_pkg::*;

    localparam int SHORT_WINDOW = 16;
    localparam int LONG_WINDOW  = 32;
    localparam int SAMPLE_BITS  = 12;
    localparam int RANDOM_ITEMS = 1100;
    localparam int BLOCK_ITEMS  = 50;
    localparam int DRAIN_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

    typedef struct packed
    {
        channel_t               ch;
        logic [SAMPLE_BITS-1:0] value;
        logic                   has_want;
        logic [SAMPLE_BITS-1:0] want;
    } stim_row_t;

    typedef struct
    {
        channel_t               ch;
        logic [SAMPLE_BITS-1:0] mean;
    } mean_beat_t;

    logic clk;
    logic rst_n;

    tcma_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_bus ();
    tcma_mean_if   #(.SAMPLE_BITS(SAMPLE_BITS)) mean_bus ();

    two_channel_moving_average #(
        .SHORT_WINDOW (SHORT_WINDOW),
        .LONG_WINDOW  (LONG_WINDOW),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_bus),
        .means   (mean_bus)
    );

    // Local copy of both rings and their running sums.
    logic [SAMPLE_BITS-1:0] short_taps [SHORT_WINDOW];
    logic [SAMPLE_BITS-1:0] long_taps  [LONG_WINDOW];
    int                     short_wr;
    int                     long_wr;
    logic [15:0]            short_total;
    logic [16:0]            long_total;

    mean_beat_t  pending_means [$];
    int          errors = 0;
    int unsigned cycle_count = 0;
    bit          src_gaps_on;
    bit          sink_gaps_on;

    // Typed means follow directly from the ring contents: a lone full-scale
    // beat, one wrap of the short ring, and a short ring full of full scale.
    stim_row_t directed_rows [23] = '{
        '{CH_SHORT, 12'd4095, 1'b1, 12'd255},
        '{CH_LONG,  12'd4095, 1'b1, 12'd127},
        '{CH_SHORT, 12'd0,    1'b1, 12'd255},
        '{CH_LONG,  12'd1,    1'b1, 12'd128},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b0, 12'd0},
        '{CH_SHORT, 12'd4095, 1'b1, 12'd4095},
        '{CH_LONG,  12'd0,    1'b0, 12'd0},
        '{CH_LONG,  12'd2048, 1'b0, 12'd0},
        '{CH_SHORT, 12'd1,    1'b0, 12'd0}
    };

    function automatic logic [SAMPLE_BITS-1:0] predict_mean(
        input channel_t ch, input logic [SAMPLE_BITS-1:0] value);
        logic [SAMPLE_BITS-1:0] avg;
        if (ch == CH_SHORT)
        begin
            short_total = short_total - short_taps[short_wr] + value;
            short_taps[short_wr] = value;
            short_wr = (short_wr == SHORT_WINDOW - 1) ? 0 : short_wr + 1;
            avg = SAMPLE_BITS'(short_total / SHORT_WINDOW);
        end
        else
        begin
            long_total = long_total - long_taps[long_wr] + value;
            long_taps[long_wr] = value;
            long_wr = (long_wr == LONG_WINDOW - 1) ? 0 : long_wr + 1;
            avg = SAMPLE_BITS'(long_total / LONG_WINDOW);
        end
        return avg;
    endfunction

    // Offers one beat after a random pause and records its mean once taken.
    task automatic drive_sample(input stim_row_t row);
        int unsigned            gap;
        logic [SAMPLE_BITS-1:0] predicted;
        mean_beat_t             beat;
        gap = src_gaps_on ? $urandom_range(0, 8) : 0;
        if (gap != 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid   <= 1'b1;
        sample_bus.channel <= row.ch;
        sample_bus.sample  <= row.value;
        do @(posedge clk); while (!sample_bus.ready);
        predicted = predict_mean(row.ch, row.value);
        beat.ch   = row.ch;
        beat.mean = row.has_want ? row.want : predicted;
        pending_means.push_back(beat);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stalls, then each taken beat is checked.
    initial
    begin
        int unsigned gap;
        mean_beat_t  exp_beat;
        mean_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = sink_gaps_on ? $urandom_range(0, 8) : 0;
            if (gap != 0)
            begin
                mean_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            mean_bus.ready <= 1'b1;
            do @(posedge clk); while (!mean_bus.valid);
            if (pending_means.size() == 0)
            begin
                $error("result beat with no expected mean: channel_out=%0d mean=%0d",
                       mean_bus.channel_out, mean_bus.mean);
                errors++;
            end
            else
            begin
                exp_beat = pending_means.pop_front();
                if (mean_bus.channel_out !== exp_beat.ch)
                begin
                    $error("channel_out: expected %0d, actual %0d",
                           exp_beat.ch, mean_bus.channel_out);
                    errors++;
                end
                if (mean_bus.mean !== exp_beat.mean)
                begin
                    $error("mean: expected %0d, actual %0d",
                           exp_beat.mean, mean_bus.mean);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned ch_mode;
        int unsigned value_mode;
        stim_row_t   row;
        short_wr    = 0;
        long_wr     = 0;
        short_total = '0;
        long_total  = '0;
        foreach (short_taps[i]) short_taps[i] = '0;
        foreach (long_taps[i]) long_taps[i] = '0;
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        rst_n              = 1'b0;
        sample_bus.valid   = 1'b0;
        sample_bus.channel = CH_SHORT;
        sample_bus.sample  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            drive_sample(directed_rows[i]);

        // Each block keeps one channel pattern and one sample pattern so that
        // whole windows fill with extremes; some blocks run without pauses.
        for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++)
        begin
            ch_mode      = $urandom_range(0, 2);
            value_mode   = $urandom_range(0, 3);
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < BLOCK_ITEMS; k++)
            begin
                case (ch_mode)
                    0:       row.ch = CH_SHORT;
                    1:       row.ch = CH_LONG;
                    default: row.ch = channel_t'($urandom_range(0, 1));
                endcase
                case (value_mode)
                    0: row.value = SAMPLE_BITS'($urandom);
                    1: row.value = ($urandom_range(0, 7) == 0) ?
                                   SAMPLE_BITS'($urandom) : FULL_SCALE;
                    2: row.value = ($urandom_range(0, 7) == 0) ?
                                   SAMPLE_BITS'($urandom_range(0, 15)) : '0;
                    default: row.value = $urandom_range(0, 1) ? FULL_SCALE : '0;
                endcase
                row.has_want = 1'b0;
                row.want     = '0;
                drive_sample(row);
            end
        end
        sample_bus.valid <= 1'b0;

        while (pending_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
rtl/tcma_pkg.sv
rtl/tcma_if.sv
rtl/tcma_ring.sv
rtl/two_channel_moving_average.sv
verif/testbench.sv
